### rtl/krl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// krl_pkg: shared widths, reset values, codes and ALU request/response types
// for the knock rhythm lock. No dependencies.

package krl_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned SCALE_W   = 8;
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  // product of 8-bit scale and 16-bit key, plus one carry bit for scaled + tolerance
  localparam int unsigned ALU_W     = 25;

  localparam int unsigned KEY_STEPS_DEF     = 5;
  localparam int unsigned FRACTION_BITS_DEF = 4;

  localparam logic [DATA_W-1:0] TOLERANCE_RST = 16'd450;
  localparam logic [DATA_W-1:0] TIMEOUT_RST   = 16'd375;
  localparam logic [DATA_W-1:0] KEY1_RST      = 16'd6000;
  localparam logic [DATA_W-1:0] KEY2_RST      = 16'd6000;
  localparam logic [DATA_W-1:0] KEY3_RST      = 16'd3000;
  localparam logic [DATA_W-1:0] KEY4_RST      = 16'd3000;

  localparam logic [ALU_W-1:0] UPPER_LIMIT = 25'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE = 3'd0,
    REG_TIMEOUT   = 3'd1,
    REG_KEY1      = 3'd2,
    REG_KEY2      = 3'd3,
    REG_KEY3      = 3'd4,
    REG_KEY4      = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUTC_NONE   = 2'd0,
    OUTC_STEP   = 2'd1,
    OUTC_UNLOCK = 2'd2,
    OUTC_REJECT = 2'd3
  } outcome_e;

  typedef enum logic {
    MODE_KNOCK = 1'b0,
    MODE_TICK  = 1'b1
  } mode_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    alu_op_e          op;
  } alu_req_t;

  // carry is "no borrow" (a >= b) for a subtract
  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

endpackage

`default_nettype wire

### rtl/krl_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// krl_alu: shared add/subtract unit of the knock lock sequencer.
// Depends on krl_pkg for the request/response types.

module krl_alu (
  input  krl_pkg::alu_req_t req_i,
  output krl_pkg::alu_rsp_t rsp_o
);
  import krl_pkg::*;

  logic             is_sub;
  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   total;

  assign is_sub = (req_i.op == ALU_SUB);
  assign b_eff  = is_sub ? ~req_i.b : req_i.b;
  assign total  = {1'b0, req_i.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, is_sub};

  assign rsp_o.sum   = total[ALU_W-1:0];
  assign rsp_o.carry = total[ALU_W];

endmodule

`default_nettype wire

### rtl/knock_rhythm_lock_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// knock_rhythm_lock_matcher: tempo-tolerant secret-knock lock, top level.
// Depends on krl_pkg and krl_alu (one shared adder/subtractor).
//
// Input channel (in_valid_i / in_stall_o): one item is a knock (mode_i = 0,
// interval_i = timer counts since the previous knock) or a timer tick.
// Every item yields one result item on out_valid_o / out_stall_i: outcome,
// unlock drive, alarm LED, failure count and the current tempo scale (4.4 if FRACTION_BITS = 4).
// Items are handled one at a time; in_stall_o is high while an item is in work.
// Work per item, from accept to result valid, with F = FRACTION_BITS:
//   tick or first knock of a sequence:  straight to the final step
//   knock at steps 2 and later:        8 multiply steps, then the bound checks
//   knock at step 1:                   16 + F divide steps first, then as above
// Every step iterates on the shared 25-bit adder/subtractor. The next item
// is taken only once the result is written, never before the previous one is
// through. A stalled receiver holds the result register; the next item may be
// taken meanwhile and its result waits in the final step until the register
// frees. Reset (rst_ni low, async) restores the default registers and clears
// the sequence, lockout, failures, scale and unlock/alarm flags. Configuration
// writes take effect at once; the user must make them only while idle, as the
// block does not enforce this. Indexes past 5 are ignored.

module knock_rhythm_lock_matcher #(
  parameter int unsigned KEY_STEPS     = krl_pkg::KEY_STEPS_DEF,
  parameter int unsigned FRACTION_BITS = krl_pkg::FRACTION_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration
  input  wire                              cfg_we_i,
  input  wire [krl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [krl_pkg::DATA_W-1:0]        cfg_wdata_i,
  // input items
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              mode_i,
  input  wire [krl_pkg::DATA_W-1:0]        interval_i,
  // result items
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [1:0]                       outcome_o,
  output logic                             unlock_drive_o,
  output logic                             alarm_led_o,
  output logic [krl_pkg::DATA_W-1:0]       failures_o,
  output logic [krl_pkg::SCALE_W-1:0]      tempo_scale_o
);
  import krl_pkg::*;

  localparam int unsigned DivW = DATA_W + FRACTION_BITS;  // dividend bits
  localparam int unsigned CntW = $clog2(DivW);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_LO_SUB = 8'b0000_1000,
    S_LO_CMP = 8'b0001_0000,
    S_HI_ADD = 8'b0010_0000,
    S_HI_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  function automatic logic [ALU_W-1:0] zext(input logic [DATA_W-1:0] v);
    return {{(ALU_W-DATA_W){1'b0}}, v};
  endfunction

  // configuration registers
  logic [DATA_W-1:0] tol_q, timeout_q, key1_q, key2_q, key3_q, key4_q;

  // sequencer and work registers
  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                mode_q, mode_d;
  logic [DATA_W-1:0]   interval_q, interval_d;
  logic [DATA_W:0]     rem_q, rem_d;
  logic [DivW-1:0]     quo_q, quo_d;        // quotient, then multiplier bits
  logic [ALU_W-1:0]    prod_q, prod_d;
  logic [ALU_W-1:0]    tmp_q, tmp_d;
  logic                low_ok_q, low_ok_d;
  logic                high_ok_q, high_ok_d;

  // lock state
  logic [STEP_W-1:0]   step_q, step_d;
  logic                lockout_q, lockout_d;
  logic [DATA_W-1:0]   fail_q, fail_d;
  logic [SCALE_W-1:0]  scale_q, scale_d;
  logic [DATA_W-1:0]   silence_q, silence_d;
  logic                unlock_q, unlock_d;
  logic                alarm_q, alarm_d;

  // output register
  logic                out_valid_q, out_valid_d;
  outcome_e            outcome_q, outcome_d;
  logic                out_unlock_q, out_unlock_d;
  logic                out_alarm_q, out_alarm_d;
  logic [DATA_W-1:0]   out_fail_q, out_fail_d;
  logic [SCALE_W-1:0]  out_scale_q, out_scale_d;

  // datapath
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  logic [DATA_W-1:0]   key_n;
  logic [ALU_W-1:0]    scaled;
  logic [ALU_W-1:0]    interval_x;
  logic [DATA_W:0]     div_shift;
  logic [DivW-1:0]     quo_next;
  logic                out_free;
  logic                pass;

  krl_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // key entry for the current step
  always_comb begin
    case (step_q)
      STEP_W'(1): key_n = key1_q;
      STEP_W'(2): key_n = key2_q;
      STEP_W'(3): key_n = key3_q;
      STEP_W'(4): key_n = key4_q;
      default:    key_n = '0;
    endcase
  end

  assign scaled     = prod_q >> FRACTION_BITS;
  assign interval_x = zext(interval_q);
  assign div_shift  = {rem_q[DATA_W-1:0], quo_q[DivW-1]};
  assign quo_next   = {quo_q[DivW-2:0], alu_rsp.carry};
  assign out_free   = !out_valid_q || !out_stall_i;

  // operand select for the shared unit
  always_comb begin
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_req.op = ALU_ADD;
    case (state_q)
      S_DIV: begin
        alu_req.a  = {{(ALU_W-DATA_W-1){1'b0}}, div_shift};
        alu_req.b  = zext(key1_q);
        alu_req.op = ALU_SUB;
      end
      S_MUL: begin
        alu_req.a  = {prod_q[ALU_W-2:0], 1'b0};
        alu_req.b  = quo_q[DivW-1] ? zext(key_n) : '0;
        alu_req.op = ALU_ADD;
      end
      S_LO_SUB: begin
        alu_req.a  = scaled;
        alu_req.b  = zext(tol_q);
        alu_req.op = ALU_SUB;
      end
      S_LO_CMP: begin
        alu_req.a  = interval_x;
        alu_req.b  = tmp_q;
        alu_req.op = ALU_SUB;
      end
      S_HI_ADD: begin
        alu_req.a  = scaled;
        alu_req.b  = zext(tol_q);
        alu_req.op = ALU_ADD;
      end
      S_HI_CMP: begin
        alu_req.a  = tmp_q;
        alu_req.b  = interval_x;
        alu_req.op = ALU_SUB;
      end
      default: begin
        alu_req.a  = '0;
        alu_req.b  = '0;
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    mode_d       = mode_q;
    interval_d   = interval_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    prod_d       = prod_q;
    tmp_d        = tmp_q;
    low_ok_d     = low_ok_q;
    high_ok_d    = high_ok_q;
    step_d       = step_q;
    lockout_d    = lockout_q;
    fail_d       = fail_q;
    scale_d      = scale_q;
    silence_d    = silence_q;
    unlock_d     = unlock_q;
    alarm_d      = alarm_q;
    out_valid_d  = out_valid_q && out_stall_i;
    outcome_d    = outcome_q;
    out_unlock_d = out_unlock_q;
    out_alarm_d  = out_alarm_q;
    out_fail_d   = out_fail_q;
    out_scale_d  = out_scale_q;
    pass         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d     = mode_i;
          interval_d = interval_i;
          cnt_d      = '0;
          if (mode_i == MODE_KNOCK && step_q != '0) begin
            if (step_q == STEP_W'(1)) begin
              // new tempo: (interval << F) / key1
              rem_d   = '0;
              quo_d   = {interval_i, {FRACTION_BITS{1'b0}}};
              state_d = S_DIV;
            end else begin
              prod_d  = '0;
              quo_d   = {scale_q, {(DivW-SCALE_W){1'b0}}};
              state_d = S_MUL;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DIV: begin
        // restoring division step; a zero key yields an all-ones quotient
        rem_d = alu_rsp.carry ? alu_rsp.sum[DATA_W:0] : div_shift;
        quo_d = quo_next;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivW-1)) begin
          scale_d = quo_next[SCALE_W-1:0];
          quo_d   = {quo_next[SCALE_W-1:0], {(DivW-SCALE_W){1'b0}}};
          prod_d  = '0;
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // shift-add, multiplier bits MSB first
        prod_d = alu_rsp.sum;
        quo_d  = quo_q << 1;
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == CntW'(SCALE_W-1)) begin
          state_d = S_LO_SUB;
        end
      end
      S_LO_SUB: begin
        if (alu_rsp.carry) begin
          tmp_d   = alu_rsp.sum;   // scaled - tolerance
          state_d = S_LO_CMP;
        end else begin
          low_ok_d = 1'b1;         // scaled below tolerance: no lower bound
          state_d  = S_HI_ADD;
        end
      end
      S_LO_CMP: begin
        low_ok_d = alu_rsp.carry;
        state_d  = S_HI_ADD;
      end
      S_HI_ADD: begin
        tmp_d   = alu_rsp.sum;     // scaled + tolerance
        state_d = S_HI_CMP;
      end
      S_HI_CMP: begin
        // upper check skipped when the bound passes 2^15
        high_ok_d = (tmp_q > UPPER_LIMIT) || alu_rsp.carry;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          if (mode_q == MODE_TICK) begin
            outcome_d = OUTC_NONE;
            if (silence_q < timeout_q) begin
              silence_d = silence_q + DATA_W'(1);
            end else begin
              alarm_d   = lockout_q;
              silence_d = '0;
              step_d    = '0;
              lockout_d = 1'b0;
            end
          end else begin
            silence_d = '0;
            unlock_d  = 1'b0;
            alarm_d   = 1'b0;
            pass = (step_q == '0) ? !lockout_q : (low_ok_q && high_ok_q);
            if (pass) begin
              if (step_q < STEP_W'(KEY_STEPS - 1)) begin
                step_d    = step_q + STEP_W'(1);
                outcome_d = OUTC_STEP;
              end else begin
                unlock_d  = 1'b1;
                step_d    = '0;
                fail_d    = '0;
                outcome_d = OUTC_UNLOCK;
              end
            end else begin
              step_d    = '0;
              lockout_d = 1'b1;
              fail_d    = fail_q + DATA_W'(1);
              outcome_d = OUTC_REJECT;
            end
          end
          out_valid_d  = 1'b1;
          out_unlock_d = unlock_d;
          out_alarm_d  = alarm_d;
          out_fail_d   = fail_d;
          out_scale_d  = scale_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= TOLERANCE_RST;
      timeout_q <= TIMEOUT_RST;
      key1_q    <= KEY1_RST;
      key2_q    <= KEY2_RST;
      key3_q    <= KEY3_RST;
      key4_q    <= KEY4_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TOLERANCE: tol_q     <= cfg_wdata_i;
        REG_TIMEOUT:   timeout_q <= cfg_wdata_i;
        REG_KEY1:      key1_q    <= cfg_wdata_i;
        REG_KEY2:      key2_q    <= cfg_wdata_i;
        REG_KEY3:      key3_q    <= cfg_wdata_i;
        REG_KEY4:      key4_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control and lock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      lockout_q   <= 1'b0;
      fail_q      <= '0;
      scale_q     <= '0;
      silence_q   <= '0;
      unlock_q    <= 1'b0;
      alarm_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      lockout_q   <= lockout_d;
      fail_q      <= fail_d;
      scale_q     <= scale_d;
      silence_q   <= silence_d;
      unlock_q    <= unlock_d;
      alarm_q     <= alarm_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    interval_q   <= interval_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    prod_q       <= prod_d;
    tmp_q        <= tmp_d;
    low_ok_q     <= low_ok_d;
    high_ok_q    <= high_ok_d;
    outcome_q    <= outcome_d;
    out_unlock_q <= out_unlock_d;
    out_alarm_q  <= out_alarm_d;
    out_fail_q   <= out_fail_d;
    out_scale_q  <= out_scale_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign outcome_o      = outcome_q;
  assign unlock_drive_o = out_unlock_q;
  assign alarm_led_o    = out_alarm_q;
  assign failures_o     = out_fail_q;
  assign tempo_scale_o  = out_scale_q;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the final step");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < STEP_W'(KEY_STEPS))
    else $error("step index beyond key length");

  a_unlock_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unlock_q |-> ((fail_q == '0) && (step_q == '0)))
    else $error("unlocked with pending failures or sequence");

  a_alarm_no_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_q |-> !lockout_q)
    else $error("alarm lit while lockout still set");
`endif

endmodule

`default_nettype wire
